// File: rtl/core/kkcs_pkg.sv
// ----------------------------------------------------------------------------
// kkcs_pkg
// Shared types and constants for the k-clustering spacing core.
// ----------------------------------------------------------------------------
package kkcs_pkg;

  localparam int unsigned NumVertices = 512;
  localparam int unsigned VtxW        = $clog2(NumVertices);
  localparam int unsigned CntW        = VtxW + 1;
  localparam int unsigned SizeW       = VtxW + 1;
  localparam int unsigned WeightW     = 16;

  localparam logic [CntW-1:0]  CntAll       = CntW'(NumVertices);
  localparam logic [CntW-1:0]  CntLast      = CntW'(NumVertices - 1);
  localparam logic [CntW-1:0]  TargetReset  = CntW'(4);
  localparam logic [SizeW-1:0] SizeOne      = SizeW'(1);

  typedef enum logic {
    REQ_EDGE  = 1'b0,
    REQ_CLEAR = 1'b1
  } req_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_RD_SRC,
    ST_RD_DST,
    ST_CMP,
    ST_SZ_SRC,
    ST_SZ_DST,
    ST_RELABEL,
    ST_CLEAR,
    ST_DONE
  } state_e;

  // Control bundle from the sequencer into the leader and size tables
  typedef struct packed {
    logic [VtxW-1:0]  ldr_raddr;
    logic             ldr_we;
    logic [VtxW-1:0]  ldr_waddr;
    logic [VtxW-1:0]  ldr_wdata;
    logic [VtxW-1:0]  sz_raddr;
    logic             sz_we;
    logic [VtxW-1:0]  sz_waddr;
    logic [SizeW-1:0] sz_wdata;
  } tbl_ctl_t;

endpackage

// File: rtl/core/kkcs_in_if.sv
// ----------------------------------------------------------------------------
// kkcs_in_if
// Request channel: edge or clear request with valid/ready handshake.
// ----------------------------------------------------------------------------
interface kkcs_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [kkcs_pkg::VtxW-1:0]   src_vertex;
  logic [kkcs_pkg::VtxW-1:0]   dst_vertex;
  logic [kkcs_pkg::WeightW-1:0] edge_weight;

  modport source (output valid, req_type, src_vertex, dst_vertex, edge_weight,
                  input ready);
  modport sink   (input valid, req_type, src_vertex, dst_vertex, edge_weight,
                  output ready);
endinterface

// File: rtl/core/kkcs_out_if.sv
// ----------------------------------------------------------------------------
// kkcs_out_if
// Result channel: merge flag, cluster count and spacing report.
// ----------------------------------------------------------------------------
interface kkcs_out_if;
  logic                         valid;
  logic                         ready;
  logic                         merged;
  logic [kkcs_pkg::CntW-1:0]    clusters_left;
  logic                         spacing_valid;
  logic [kkcs_pkg::WeightW-1:0] spacing;

  modport source (output valid, merged, clusters_left, spacing_valid, spacing,
                  input ready);
  modport sink   (input valid, merged, clusters_left, spacing_valid, spacing,
                  output ready);
endinterface

// File: rtl/core/kkcs_tables.sv
// ----------------------------------------------------------------------------
// kkcs_tables
// Leader and cluster-size memories, one write and one registered read each.
// ----------------------------------------------------------------------------
module kkcs_tables (
  input  logic                             clk_i,
  input  kkcs_pkg::tbl_ctl_t               ctl_i,
  output logic [kkcs_pkg::VtxW-1:0]        ldr_rdata_o,
  output logic [kkcs_pkg::SizeW-1:0]       sz_rdata_o
);

  logic [kkcs_pkg::VtxW-1:0]  ldr_mem [kkcs_pkg::NumVertices];
  logic [kkcs_pkg::SizeW-1:0] sz_mem  [kkcs_pkg::NumVertices];

  always_ff @(posedge clk_i) begin
    if (ctl_i.ldr_we) begin
      ldr_mem[ctl_i.ldr_waddr] <= ctl_i.ldr_wdata;
    end
    ldr_rdata_o <= ldr_mem[ctl_i.ldr_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.sz_we) begin
      sz_mem[ctl_i.sz_waddr] <= ctl_i.sz_wdata;
    end
    sz_rdata_o <= sz_mem[ctl_i.sz_raddr];
  end

endmodule

// File: rtl/core/kruskal_k_clustering_spacing_core.sv
// ----------------------------------------------------------------------------
// kruskal_k_clustering_spacing_core
// Single-linkage k-clustering over a sorted edge stream, max-spacing report.
// ----------------------------------------------------------------------------
// Edges go in one at a time; each transfer yields exactly one result. After
// reset the core sweeps both tables and holds in_i.ready low meanwhile; a
// clear request repeats that sweep. An edge that merges two clusters
// relabels the loser's members by one pass over the leader table, one vertex
// a cycle through a single compare unit. Any other edge skips that pass.
// A finished result sits in an output register, so the next request is taken
// while the previous result waits. target_clusters is written through
// cfg_we_i/cfg_wdata_i; the user must do so only while the core is idle, as
// the block itself does not enforce it.
module kruskal_k_clustering_spacing_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  kkcs_in_if.sink                       in_i,
  kkcs_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [kkcs_pkg::CntW-1:0]     cfg_wdata_i
);

  kkcs_pkg::state_e state_q, state_d;

  logic [kkcs_pkg::CntW-1:0]    target_q;
  logic [kkcs_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [kkcs_pkg::VtxW-1:0]    src_q, src_d, dst_q, dst_d;
  logic [kkcs_pkg::WeightW-1:0] wgt_q, wgt_d;
  logic [kkcs_pkg::VtxW-1:0]    sl_q, sl_d, dl_q, dl_d;
  logic [kkcs_pkg::SizeW-1:0]   szs_q, szs_d, sum_q, sum_d;
  logic [kkcs_pkg::VtxW-1:0]    win_q, win_d, lose_q, lose_d;
  logic [kkcs_pkg::CntW-1:0]    count_q, count_d;
  logic                         found_q, found_d;
  logic [kkcs_pkg::WeightW-1:0] spacing_q, spacing_d;
  logic                         merged_q, merged_d;

  logic                         ov_q, ov_d;
  logic                         om_q, om_d;
  logic [kkcs_pkg::CntW-1:0]    oleft_q, oleft_d;
  logic                         osv_q, osv_d;
  logic [kkcs_pkg::WeightW-1:0] osp_q, osp_d;

  kkcs_pkg::tbl_ctl_t           tbl_ctl;
  logic [kkcs_pkg::VtxW-1:0]    ldr_rdata;
  logic [kkcs_pkg::SizeW-1:0]   sz_rdata;
  logic [kkcs_pkg::CntW-1:0]    cnt_prev;

  kkcs_tables u_tables (
    .clk_i       (clk_i),
    .ctl_i       (tbl_ctl),
    .ldr_rdata_o (ldr_rdata),
    .sz_rdata_o  (sz_rdata)
  );

  assign cnt_prev = cnt_q - kkcs_pkg::CntW'(1);

  assign in_i.ready          = (state_q == kkcs_pkg::ST_IDLE);
  assign out_o.valid         = ov_q;
  assign out_o.merged        = om_q;
  assign out_o.clusters_left = oleft_q;
  assign out_o.spacing_valid = osv_q;
  assign out_o.spacing       = osp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= kkcs_pkg::TargetReset;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= kkcs_pkg::ST_INIT;
      cnt_q     <= '0;
      count_q   <= kkcs_pkg::CntAll;
      found_q   <= 1'b0;
      spacing_q <= '0;
      merged_q  <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      count_q   <= count_d;
      found_q   <= found_d;
      spacing_q <= spacing_d;
      merged_q  <= merged_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q   <= src_d;
    dst_q   <= dst_d;
    wgt_q   <= wgt_d;
    sl_q    <= sl_d;
    dl_q    <= dl_d;
    szs_q   <= szs_d;
    sum_q   <= sum_d;
    win_q   <= win_d;
    lose_q  <= lose_d;
    om_q    <= om_d;
    oleft_q <= oleft_d;
    osv_q   <= osv_d;
    osp_q   <= osp_d;
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    src_d     = src_q;
    dst_d     = dst_q;
    wgt_d     = wgt_q;
    sl_d      = sl_q;
    dl_d      = dl_q;
    szs_d     = szs_q;
    sum_d     = sum_q;
    win_d     = win_q;
    lose_d    = lose_q;
    count_d   = count_q;
    found_d   = found_q;
    spacing_d = spacing_q;
    merged_d  = merged_q;
    ov_d      = ov_q;
    om_d      = om_q;
    oleft_d   = oleft_q;
    osv_d     = osv_q;
    osp_d     = osp_q;

    tbl_ctl           = '0;
    tbl_ctl.ldr_raddr = src_q;
    tbl_ctl.sz_raddr  = sl_q;

    // drop the result once the sink takes it
    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      kkcs_pkg::ST_INIT, kkcs_pkg::ST_CLEAR: begin
        tbl_ctl.ldr_we    = 1'b1;
        tbl_ctl.ldr_waddr = cnt_q[kkcs_pkg::VtxW-1:0];
        tbl_ctl.ldr_wdata = cnt_q[kkcs_pkg::VtxW-1:0];
        tbl_ctl.sz_we     = 1'b1;
        tbl_ctl.sz_waddr  = cnt_q[kkcs_pkg::VtxW-1:0];
        tbl_ctl.sz_wdata  = kkcs_pkg::SizeOne;
        cnt_d             = cnt_q + kkcs_pkg::CntW'(1);
        if (cnt_q == kkcs_pkg::CntLast) begin
          cnt_d     = '0;
          count_d   = kkcs_pkg::CntAll;
          found_d   = 1'b0;
          spacing_d = '0;
          state_d   = (state_q == kkcs_pkg::ST_INIT) ? kkcs_pkg::ST_IDLE
                                                     : kkcs_pkg::ST_DONE;
        end
      end

      kkcs_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          src_d    = in_i.src_vertex;
          dst_d    = in_i.dst_vertex;
          wgt_d    = in_i.edge_weight;
          merged_d = 1'b0;
          cnt_d    = '0;
          state_d  = (in_i.req_type == kkcs_pkg::REQ_CLEAR) ? kkcs_pkg::ST_CLEAR
                                                            : kkcs_pkg::ST_RD_SRC;
        end
      end

      kkcs_pkg::ST_RD_SRC: begin
        tbl_ctl.ldr_raddr = src_q;
        state_d           = kkcs_pkg::ST_RD_DST;
      end

      kkcs_pkg::ST_RD_DST: begin
        tbl_ctl.ldr_raddr = dst_q;
        sl_d              = ldr_rdata;
        state_d           = kkcs_pkg::ST_CMP;
      end

      kkcs_pkg::ST_CMP: begin
        dl_d             = ldr_rdata;
        tbl_ctl.sz_raddr = sl_q;
        state_d          = kkcs_pkg::ST_DONE;
        if (sl_q != ldr_rdata) begin
          if (count_q > target_q) begin
            state_d = kkcs_pkg::ST_SZ_SRC;
          end else if (!found_q) begin
            found_d   = 1'b1;
            spacing_d = wgt_q;
          end
        end
      end

      kkcs_pkg::ST_SZ_SRC: begin
        szs_d            = sz_rdata;
        tbl_ctl.sz_raddr = dl_q;
        state_d          = kkcs_pkg::ST_SZ_DST;
      end

      kkcs_pkg::ST_SZ_DST: begin
        // larger cluster keeps its leader; on a tie the destination side wins
        if (szs_q > sz_rdata) begin
          win_d  = sl_q;
          lose_d = dl_q;
        end else begin
          win_d  = dl_q;
          lose_d = sl_q;
        end
        sum_d   = szs_q + sz_rdata;
        cnt_d   = '0;
        state_d = kkcs_pkg::ST_RELABEL;
      end

      kkcs_pkg::ST_RELABEL: begin
        // read vertex cnt, compare and rewrite vertex cnt-1 in the same cycle
        tbl_ctl.ldr_raddr = cnt_q[kkcs_pkg::VtxW-1:0];
        tbl_ctl.ldr_waddr = cnt_prev[kkcs_pkg::VtxW-1:0];
        tbl_ctl.ldr_wdata = win_q;
        tbl_ctl.ldr_we    = (cnt_q != '0) && (ldr_rdata == lose_q);
        cnt_d             = cnt_q + kkcs_pkg::CntW'(1);
        if (cnt_q == kkcs_pkg::CntAll) begin
          tbl_ctl.sz_we    = 1'b1;
          tbl_ctl.sz_waddr = win_q;
          tbl_ctl.sz_wdata = sum_q;
          count_d          = count_q - kkcs_pkg::CntW'(1);
          merged_d         = 1'b1;
          cnt_d            = '0;
          state_d          = kkcs_pkg::ST_DONE;
        end
      end

      kkcs_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!ov_q || out_o.ready) begin
          ov_d    = 1'b1;
          om_d    = merged_q;
          oleft_d = count_q;
          osv_d   = found_q;
          osp_d   = spacing_q;
          state_d = kkcs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = kkcs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: tb/sv/kruskal_k_clustering_spacing_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kruskal_k_clustering_spacing_core_test
// Streams edge and clear requests into the clustering core and checks every
// report against a cycle-free model of the leader and size tables, under
// random back-pressure on both channels and several target settings.
// ----------------------------------------------------------------------------
module kruskal_k_clustering_spacing_core_test;
  import kkcs_pkg::*;

  localparam int unsigned IdleLimit   = 20000;
  localparam int unsigned HoldCycles  = 700;
  localparam int unsigned DrainCycles = 600;
  localparam int unsigned RandomItems = 1170;

  typedef struct packed {
    logic               merged;
    logic [CntW-1:0]    clusters_left;
    logic               spacing_valid;
    logic [WeightW-1:0] spacing;
  } cluster_report_t;

  class cluster_scoreboard;
    logic [VtxW-1:0]    leader_of [NumVertices];
    logic [SizeW-1:0]   size_of [NumVertices];
    logic [CntW-1:0]    clusters;
    logic [CntW-1:0]    target;
    logic               spaced;
    logic [WeightW-1:0] spacing;
    cluster_report_t    awaited_reports [$];
    int unsigned        errors;

    function new();
      target = TargetReset;
      errors = 0;
      make_singletons();
    endfunction

    function void make_singletons();
      foreach (leader_of[v]) begin
        leader_of[v] = VtxW'(v);
        size_of[v]   = SizeOne;
      end
      clusters = CntAll;
      spaced   = 1'b0;
      spacing  = '0;
    endfunction

    function void set_target(logic [CntW-1:0] value);
      target = value;
    endfunction

    function int unsigned pending();
      return awaited_reports.size();
    endfunction

    function void note_request(req_e req, logic [VtxW-1:0] src, logic [VtxW-1:0] dst,
                               logic [WeightW-1:0] weight);
      logic [VtxW-1:0] src_ldr;
      logic [VtxW-1:0] dst_ldr;
      logic [VtxW-1:0] winner;
      logic [VtxW-1:0] loser;
      cluster_report_t rep;
      rep.merged = 1'b0;
      if (req == REQ_CLEAR) begin
        make_singletons();
      end else begin
        src_ldr = leader_of[src];
        dst_ldr = leader_of[dst];
        if (src_ldr != dst_ldr) begin
          if (clusters > target) begin
            // larger cluster keeps its leader; a tie goes to the destination
            if (size_of[src_ldr] > size_of[dst_ldr]) begin
              winner = src_ldr;
              loser  = dst_ldr;
            end else begin
              winner = dst_ldr;
              loser  = src_ldr;
            end
            foreach (leader_of[v]) begin
              if (leader_of[v] == loser) leader_of[v] = winner;
            end
            size_of[winner] = size_of[winner] + size_of[loser];
            clusters = clusters - CntW'(1);
            rep.merged = 1'b1;
          end else if (!spaced) begin
            spaced  = 1'b1;
            spacing = weight;
          end
        end
      end
      rep.clusters_left = clusters;
      rep.spacing_valid = spaced;
      rep.spacing       = spaced ? spacing : '0;
      awaited_reports.push_back(rep);
    endfunction

    function void check_result(cluster_report_t got);
      cluster_report_t want;
      if (awaited_reports.size() == 0) begin
        $error("report with nothing awaited: merged %0d clusters_left %0d",
               got.merged, got.clusters_left);
        errors++;
        return;
      end
      want = awaited_reports.pop_front();
      if (got.merged !== want.merged) begin
        $error("merged: expected %0d, actual %0d", want.merged, got.merged);
        errors++;
      end
      if (got.clusters_left !== want.clusters_left) begin
        $error("clusters_left: expected %0d, actual %0d", want.clusters_left,
               got.clusters_left);
        errors++;
      end
      if (got.spacing_valid !== want.spacing_valid) begin
        $error("spacing_valid: expected %0d, actual %0d", want.spacing_valid,
               got.spacing_valid);
        errors++;
      end
      if (got.spacing !== want.spacing) begin
        $error("spacing: expected %0d, actual %0d", want.spacing, got.spacing);
        errors++;
      end
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we;
  logic [CntW-1:0] cfg_wdata;

  kkcs_in_if  edge_if ();
  kkcs_out_if report_if ();

  cluster_scoreboard sb = new();

  bit          hold_req     = 1'b0;
  bit          no_idle      = 1'b0;
  int unsigned burst_left   = 0;
  int unsigned random_sent  = 0;
  int unsigned quiet_cycles = 0;

  kruskal_k_clustering_spacing_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (edge_if),
    .out_o       (report_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((edge_if.valid === 1'b1 && edge_if.ready === 1'b1) ||
        (report_if.valid === 1'b1 && report_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("kruskal_k_clustering_spacing_core_test: done, errors");
        $finish;
      end
    end
  end

  task automatic push_request(input req_e req, input logic [VtxW-1:0] src,
                              input logic [VtxW-1:0] dst, input logic [WeightW-1:0] weight);
    int unsigned gap;
    gap = (no_idle || burst_left > 0) ? 0 : $urandom_range(0, 11);
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    if (gap > 0) begin
      edge_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    edge_if.valid       <= 1'b1;
    edge_if.req_type    <= req;
    edge_if.src_vertex  <= src;
    edge_if.dst_vertex  <= dst;
    edge_if.edge_weight <= weight;
    do @(posedge clk_i); while (edge_if.ready !== 1'b1);
    sb.note_request(req, src, dst, weight);
  endtask

  task automatic send_edge(input int unsigned src, input int unsigned dst,
                           input int unsigned weight);
    push_request(REQ_EDGE, VtxW'(src), VtxW'(dst), WeightW'(weight));
  endtask

  task automatic send_clear();
    push_request(REQ_CLEAR, VtxW'($urandom), VtxW'($urandom), WeightW'($urandom));
  endtask

  // Drop valid and hold until every awaited report has been taken
  task automatic settle();
    @(negedge clk_i);
    edge_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_target(input int unsigned value);
    settle();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= CntW'(value);
    @(posedge clk_i);
    sb.set_target(CntW'(value));
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned phase);
    int unsigned pool_n;
    int unsigned base;
    int unsigned stride;
    int unsigned len;
    int unsigned weight;
    int unsigned sel;
    int unsigned a;
    int unsigned b;
    sel = $urandom_range(0, 9);
    pool_n = $urandom_range(4, 48);
    case (sel)
      0: write_target(0);
      1: write_target(1);
      2: write_target(NumVertices);
      3: write_target($urandom_range(1, NumVertices));
      default: write_target(NumVertices - $urandom_range(0, pool_n));
    endcase
    no_idle = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 3) != 0) begin
      send_clear();
      random_sent++;
    end
    base   = $urandom_range(0, NumVertices - 1);
    stride = 2 * $urandom_range(0, 255) + 1;
    len    = $urandom_range(40, 120);
    weight = $urandom_range(0, 60000);
    for (int unsigned k = 0; k < len; k++) begin
      if (phase == 1 && k == 5) begin
        // stall the report side while requests keep coming back to back
        hold_req   = 1'b1;
        burst_left = 12;
      end
      if (phase == 3 && k == len / 2) settle();
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        send_clear();
      end else if (sel <= 2) begin
        send_edge($urandom_range(0, NumVertices - 1), $urandom_range(0, NumVertices - 1),
                  $urandom_range(0, 65535));
      end else begin
        a = (base + $urandom_range(0, pool_n - 1) * stride) % NumVertices;
        b = (base + $urandom_range(0, pool_n - 1) * stride) % NumVertices;
        if ($urandom_range(0, 3) == 0) weight = weight + $urandom_range(0, 40);
        if (weight > 65535) weight = 65535;
        send_edge(a, b, weight);
      end
      random_sent++;
    end
  endtask

  initial begin : report_sink
    int unsigned gap;
    cluster_report_t got;
    report_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HoldCycles;
      end else if (no_idle) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 11);
      end
      @(negedge clk_i);
      if (gap > 0) begin
        report_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      report_if.ready <= 1'b1;
      do @(posedge clk_i); while (report_if.valid !== 1'b1);
      got.merged        = report_if.merged;
      got.clusters_left = report_if.clusters_left;
      got.spacing_valid = report_if.spacing_valid;
      got.spacing       = report_if.spacing;
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    int unsigned phase;
    rst_ni              <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    edge_if.valid       <= 1'b0;
    edge_if.req_type    <= REQ_EDGE;
    edge_if.src_vertex  <= '0;
    edge_if.dst_vertex  <= '0;
    edge_if.edge_weight <= '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset target of four: ties, larger-wins, same cluster, self loop
    send_edge(0, 511, 0);
    send_edge(511, 0, 0);
    send_edge(5, 5, 1);
    send_edge(1, 0, 1);
    send_edge(0, 2, 2);
    send_edge(341, 170, 16'h5555);
    send_edge(170, 1, 16'hAAAA);
    push_request(REQ_CLEAR, 9'h1FF, 9'h1FF, 16'hFFFF);
    send_edge(511, 0, 16'hFFFF);
    // target above the count latches at once; later edges change nothing
    write_target(NumVertices);
    send_edge(3, 4, 16'h8001);
    send_edge(6, 7, 16'hFFFF);
    // a lower target resumes merging even with spacing latched
    write_target(1);
    send_edge(8, 9, 16'h0010);
    send_clear();
    send_edge(256, 255, 16'h0100);
    // zero target never latches
    write_target(0);
    send_edge(255, 128, 16'h0200);
    send_edge(128, 256, 16'h0300);
    send_edge(1, 2, 16'hFFFF);
    write_target(NumVertices - 1);
    send_edge(10, 11, 16'h7FFF);
    send_clear();
    send_edge(12, 13, 0);
    send_edge(14, 15, 1);

    phase = 0;
    while (random_sent < RandomItems) begin
      run_phase(phase);
      phase++;
    end

    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("kruskal_k_clustering_spacing_core_test: done, clean");
    end else begin
      $display("kruskal_k_clustering_spacing_core_test: done, errors");
    end
    $finish;
  end

endmodule
